### design/ppw_pkg.sv
// ----------------------------------------------------------------------------
// ppw_pkg: shared constants for the Panini projection warp
// Fixed-point format, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package ppw_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 24;
  localparam int DIST_W    = 21;
  localparam int SQZ_W     = 17;
  localparam int CFG_IDX_W = 1;

  // Unity in Q1.16
  localparam logic [SQZ_W-1:0] ONE_Q = SQZ_W'(1) << FRAC_BITS;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SQZ  = 1'd1;

  typedef logic signed [FIELD_W-1:0] field_t;

endpackage

### design/panini_projection_warp.sv
// Throughput: one word per cycle; the whole cell chain advances together
// whenever the output register is empty or being taken.
// Reset (synchronous, rst_n low) empties the pipeline and loads
// projection_distance = 1.0 and vertical_squeeze = 0.
// ----------------------------------------------------------------------------
// panini_projection_warp: Panini projection of screen-plane points
// Square roots and divisions run as chains of one-bit cells in Q8.16.
// ----------------------------------------------------------------------------
module panini_projection_warp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [47:0]                    in_tdata,   // point_x[23:0], point_y[47:24]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [47:0]                    out_tdata,  // warped_x[23:0], warped_y[47:24]
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ppw_pkg::DIST_W-1:0]     cfg_data
);

  import ppw_pkg::*;

  localparam int RN = 24;  // root of x^2 + 1
  localparam int QN = 24;  // sine and tangent quotients
  localparam int CN = 17;  // cosine root
  localparam int BN = 41;  // tan * s / cos quotient
  localparam int FN = 46;  // final scale quotients

  logic en;

  // Configuration registers
  logic [DIST_W-1:0] dist_r;
  logic [SQZ_W-1:0]  sqz_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= DIST_W'(32'd65536);
      sqz_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DIST: dist_r <= cfg_data;
        REG_SQZ:  sqz_r  <= cfg_data[SQZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole chain moves when the output register can take a word
  logic out_vld_r;
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  // Input stage: magnitudes and radicand x^2 + 1
  field_t      px, py;
  logic [23:0] xm, ym;
  logic        s0_vld_r;
  logic [47:0] s0_rad_r;
  logic [49:0] s0_side_r;

  assign px = in_tdata[23:0];
  assign py = in_tdata[47:24];
  assign xm = px[23] ? 24'(~px + 24'd1) : px;
  assign ym = py[23] ? 24'(~py + 24'd1) : py;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_rad_r  <= 48'(xm) * 48'(xm) + 48'h1_0000_0000;
      s0_side_r <= {px[23], py[23], ym, xm};
    end
  end

  // Root chain r = sqrt(x^2 + 1)
  logic        r_vld  [0:RN];
  logic [47:0] r_rad  [0:RN];
  logic [47:0] r_root [0:RN];
  logic [49:0] r_side [0:RN];

  assign r_vld[0]  = s0_vld_r;
  assign r_rad[0]  = s0_rad_r;
  assign r_root[0] = '0;
  assign r_side[0] = s0_side_r;

  for (genvar k = 0; k < RN; k++) begin : g_rt
    ppw_sqrt_cell #(.W(48), .STEP(k), .SW(50)) u_cell (
      .clk, .rst_n, .en,
      .vld_i (r_vld[k]),   .rad_i (r_rad[k]),   .root_i (r_root[k]),   .side_i (r_side[k]),
      .vld_o (r_vld[k+1]), .rad_o (r_rad[k+1]), .root_o (r_root[k+1]), .side_o (r_side[k+1])
    );
  end

  // Sine and tangent chains: (x << 16) / r and (y << 16) / r
  logic        sn_vld [0:QN], tn_vld [0:QN];
  logic [39:0] sn_rem [0:QN], tn_rem [0:QN];
  logic [23:0] sn_dvs [0:QN], tn_dvs [0:QN];
  logic [23:0] sn_quo [0:QN], tn_quo [0:QN];
  logic [0:0]  sn_sd  [0:QN], tn_sd  [0:QN];

  assign sn_vld[0] = r_vld[RN];
  assign tn_vld[0] = r_vld[RN];
  assign sn_rem[0] = {r_side[RN][23:0], 16'd0};
  assign tn_rem[0] = {r_side[RN][47:24], 16'd0};
  assign sn_dvs[0] = r_root[RN][23:0];
  assign tn_dvs[0] = r_root[RN][23:0];
  assign sn_quo[0] = '0;
  assign tn_quo[0] = '0;
  assign sn_sd[0]  = r_side[RN][49];
  assign tn_sd[0]  = r_side[RN][48];

  for (genvar k = 0; k < QN; k++) begin : g_st
    ppw_div_cell #(.NW(40), .DW(24), .QW(24), .SH(QN-1-k), .SW(1)) u_sin (
      .clk, .rst_n, .en,
      .vld_i (sn_vld[k]),   .rem_i (sn_rem[k]),   .dvs_i (sn_dvs[k]),
      .quo_i (sn_quo[k]),   .side_i (sn_sd[k]),
      .vld_o (sn_vld[k+1]), .rem_o (sn_rem[k+1]), .dvs_o (sn_dvs[k+1]),
      .quo_o (sn_quo[k+1]), .side_o (sn_sd[k+1])
    );
    ppw_div_cell #(.NW(40), .DW(24), .QW(24), .SH(QN-1-k), .SW(1)) u_tan (
      .clk, .rst_n, .en,
      .vld_i (tn_vld[k]),   .rem_i (tn_rem[k]),   .dvs_i (tn_dvs[k]),
      .quo_i (tn_quo[k]),   .side_i (tn_sd[k]),
      .vld_o (tn_vld[k+1]), .rem_o (tn_rem[k+1]), .dvs_o (tn_dvs[k+1]),
      .quo_o (tn_quo[k+1]), .side_o (tn_sd[k+1])
    );
  end

  // Cap sine below one, form cosine radicand 1 - sin^2
  logic [15:0] sin_cap;
  logic        s1_vld_r;
  logic [33:0] s1_rad_r;
  logic [41:0] s1_side_r;

  assign sin_cap = (sn_quo[QN] > 24'd65535) ? 16'hFFFF : sn_quo[QN][15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= sn_vld[QN] & tn_vld[QN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rad_r  <= 34'h1_0000_0000 - 34'(32'(sin_cap) * 32'(sin_cap));
      s1_side_r <= {sn_sd[QN], tn_sd[QN], tn_quo[QN], sin_cap};
    end
  end

  // Cosine root chain
  logic        c_vld  [0:CN];
  logic [33:0] c_rad  [0:CN];
  logic [33:0] c_root [0:CN];
  logic [41:0] c_side [0:CN];

  assign c_vld[0]  = s1_vld_r;
  assign c_rad[0]  = s1_rad_r;
  assign c_root[0] = '0;
  assign c_side[0] = s1_side_r;

  for (genvar k = 0; k < CN; k++) begin : g_ct
    ppw_sqrt_cell #(.W(34), .STEP(k), .SW(42)) u_cell (
      .clk, .rst_n, .en,
      .vld_i (c_vld[k]),   .rad_i (c_rad[k]),   .root_i (c_root[k]),   .side_i (c_side[k]),
      .vld_o (c_vld[k+1]), .rad_o (c_rad[k+1]), .root_o (c_root[k+1]), .side_o (c_side[k+1])
    );
  end

  // Squeeze products: tan * s and tan * (1 - s)
  logic [SQZ_W-1:0] sqz_cap;
  logic [23:0]      tan_c;
  logic [16:0]      cos_c;
  logic [40:0]      keep_prod;
  logic             s2_vld_r;
  logic [40:0]      s2_ts_r;
  logic [16:0]      s2_cos_r;
  logic [58:0]      s2_side_r;

  assign sqz_cap   = (sqz_r > ONE_Q) ? ONE_Q : sqz_r;
  assign tan_c     = c_side[CN][39:16];
  assign cos_c     = c_root[CN][16:0];
  assign keep_prod = 41'(tan_c) * 41'(ONE_Q - sqz_cap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= c_vld[CN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ts_r   <= 41'(tan_c) * 41'(sqz_cap);
      s2_cos_r  <= cos_c;
      s2_side_r <= {cos_c, keep_prod[39:16], c_side[CN][15:0], c_side[CN][41:40]};
    end
  end

  // Blend chain: tan * s / cos
  logic        b_vld [0:BN];
  logic [40:0] b_rem [0:BN];
  logic [16:0] b_dvs [0:BN];
  logic [40:0] b_quo [0:BN];
  logic [58:0] b_sd  [0:BN];

  assign b_vld[0] = s2_vld_r;
  assign b_rem[0] = s2_ts_r;
  assign b_dvs[0] = s2_cos_r;
  assign b_quo[0] = '0;
  assign b_sd[0]  = s2_side_r;

  for (genvar k = 0; k < BN; k++) begin : g_bt
    ppw_div_cell #(.NW(41), .DW(17), .QW(41), .SH(BN-1-k), .SW(59)) u_cell (
      .clk, .rst_n, .en,
      .vld_i (b_vld[k]),   .rem_i (b_rem[k]),   .dvs_i (b_dvs[k]),
      .quo_i (b_quo[k]),   .side_i (b_sd[k]),
      .vld_o (b_vld[k+1]), .rem_o (b_rem[k+1]), .dvs_o (b_dvs[k+1]),
      .quo_o (b_quo[k+1]), .side_o (b_sd[k+1])
    );
  end

  // Sum and cap the blend, form numerator and denominator of the scale
  logic [41:0] bsum;
  logic        s3_vld_r;
  logic [23:0] s3_blend_r;
  logic [15:0] s3_sin_r;
  logic [21:0] s3_num_r, s3_den_r;
  logic [1:0]  s3_neg_r;

  assign bsum = 42'(b_quo[BN]) + 42'(b_sd[BN][41:18]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= b_vld[BN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_blend_r <= (bsum > 42'h80_0000) ? 24'h80_0000 : bsum[23:0];
      s3_sin_r   <= b_sd[BN][17:2];
      s3_num_r   <= 22'(dist_r) + 22'(ONE_Q);
      s3_den_r   <= 22'(dist_r) + 22'(b_sd[BN][58:42]);
      s3_neg_r   <= b_sd[BN][1:0];
    end
  end

  // Scale numerators
  logic        s4_vld_r;
  logic [45:0] s4_nx_r, s4_ny_r;
  logic [21:0] s4_den_r;
  logic [1:0]  s4_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nx_r  <= 46'(s3_sin_r) * 46'(s3_num_r);
      s4_ny_r  <= 46'(s3_blend_r) * 46'(s3_num_r);
      s4_den_r <= s3_den_r;
      s4_neg_r <= s3_neg_r;
    end
  end

  // Final scale chains for x and y
  logic        fx_vld [0:FN], fy_vld [0:FN];
  logic [45:0] fx_rem [0:FN], fy_rem [0:FN];
  logic [21:0] fx_dvs [0:FN], fy_dvs [0:FN];
  logic [45:0] fx_quo [0:FN], fy_quo [0:FN];
  logic [0:0]  fx_sd  [0:FN], fy_sd  [0:FN];

  assign fx_vld[0] = s4_vld_r;
  assign fy_vld[0] = s4_vld_r;
  assign fx_rem[0] = s4_nx_r;
  assign fy_rem[0] = s4_ny_r;
  assign fx_dvs[0] = s4_den_r;
  assign fy_dvs[0] = s4_den_r;
  assign fx_quo[0] = '0;
  assign fy_quo[0] = '0;
  assign fx_sd[0]  = s4_neg_r[1];
  assign fy_sd[0]  = s4_neg_r[0];

  for (genvar k = 0; k < FN; k++) begin : g_ft
    ppw_div_cell #(.NW(46), .DW(22), .QW(46), .SH(FN-1-k), .SW(1)) u_x (
      .clk, .rst_n, .en,
      .vld_i (fx_vld[k]),   .rem_i (fx_rem[k]),   .dvs_i (fx_dvs[k]),
      .quo_i (fx_quo[k]),   .side_i (fx_sd[k]),
      .vld_o (fx_vld[k+1]), .rem_o (fx_rem[k+1]), .dvs_o (fx_dvs[k+1]),
      .quo_o (fx_quo[k+1]), .side_o (fx_sd[k+1])
    );
    ppw_div_cell #(.NW(46), .DW(22), .QW(46), .SH(FN-1-k), .SW(1)) u_y (
      .clk, .rst_n, .en,
      .vld_i (fy_vld[k]),   .rem_i (fy_rem[k]),   .dvs_i (fy_dvs[k]),
      .quo_i (fy_quo[k]),   .side_i (fy_sd[k]),
      .vld_o (fy_vld[k+1]), .rem_o (fy_rem[k+1]), .dvs_o (fy_dvs[k+1]),
      .quo_o (fy_quo[k+1]), .side_o (fy_sd[k+1])
    );
  end

  // Saturate a magnitude with sign into the output field
  function automatic field_t sat_enc(input logic [45:0] mag, input logic neg);
    field_t res;
    if (neg) begin
      res = (mag >= 46'h80_0000) ? 24'h80_0000 : 24'(~mag[23:0] + 24'd1);
    end else begin
      res = (mag > 46'h7F_FFFF) ? 24'h7F_FFFF : mag[23:0];
    end
    return res;
  endfunction

  // Output register
  logic [47:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= fx_vld[FN] & fy_vld[FN];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {sat_enc(fy_quo[FN], fy_sd[FN][0]), sat_enc(fx_quo[FN], fx_sd[FN][0])};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

### design/ppw_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ppw_sqrt_cell: one step of a pipelined integer square root
// Resolves one root bit per cell and hands remainder and root onward.
// ----------------------------------------------------------------------------
module ppw_sqrt_cell #(
  parameter int W    = 48,
  parameter int STEP = 0,
  parameter int SW   = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [W-1:0]  rad_i,
  input  logic [W-1:0]  root_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [W-1:0]  rad_o,
  output logic [W-1:0]  root_o,
  output logic [SW-1:0] side_o
);

  localparam int BP = W - 2 - 2 * STEP;
  localparam logic [W:0] BIT_W = (W + 1)'(1) << BP;

  logic [W:0]    trial;
  logic          take;
  logic [W-1:0]  rad_nxt, root_nxt;
  logic          vld_r;
  logic [W-1:0]  rad_r, root_r;
  logic [SW-1:0] side_r;

  // Trial subtract of root plus the current bit
  assign trial = {1'b0, root_i} + BIT_W;
  assign take  = {1'b0, rad_i} >= trial;

  always_comb begin
    if (take) begin
      rad_nxt  = W'({1'b0, rad_i} - trial);
      root_nxt = W'({1'b0, root_i >> 1} + BIT_W);
    end else begin
      rad_nxt  = rad_i;
      root_nxt = root_i >> 1;
    end
  end

  // Advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rad_o  = rad_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

### design/ppw_div_cell.sv
// ----------------------------------------------------------------------------
// ppw_div_cell: one step of a pipelined restoring divider
// Resolves quotient bit SH and passes remainder, divisor and quotient on.
// ----------------------------------------------------------------------------
module ppw_div_cell #(
  parameter int NW = 40,
  parameter int DW = 24,
  parameter int QW = 24,
  parameter int SH = 0,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] rem_i,
  input  logic [DW-1:0] dvs_i,
  input  logic [QW-1:0] quo_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [NW-1:0] rem_o,
  output logic [DW-1:0] dvs_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int CW = (NW > DW + SH) ? NW : DW + SH;

  logic [CW-1:0] rem_w, sub_w;
  logic          take;
  logic [NW-1:0] rem_nxt;
  logic [QW-1:0] quo_nxt;
  logic          vld_r;
  logic [NW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [QW-1:0] quo_r;
  logic [SW-1:0] side_r;

  // Compare remainder against the shifted divisor
  assign rem_w = CW'(rem_i);
  assign sub_w = CW'(dvs_i) << SH;
  assign take  = rem_w >= sub_w;

  always_comb begin
    quo_nxt     = quo_i;
    quo_nxt[SH] = take;
    rem_nxt     = take ? NW'(rem_w - sub_w) : rem_i;
  end

  // Advance on enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      dvs_r  <= dvs_i;
      quo_r  <= quo_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign dvs_o  = dvs_r;
  assign quo_o  = quo_r;
  assign side_o = side_r;

endmodule
